[design/clqm_pkg.sv]
// ----------------------------------------------------------------------------
// Circular linked queue manager - shared package
// Sizes, action and status codes and the request/response records.
// ----------------------------------------------------------------------------
`default_nettype none

package clqm_pkg;

    localparam int ELEMENTS = 16;
    localparam int QUEUES   = 4;

    localparam int ELEM_W   = 4;
    localparam int QUEUE_W  = 2;
    localparam int COUNT_W  = $clog2(ELEMENTS + 1);
    localparam int ACTION_W = 2;

    // Range limits, one bit wider than the fields they bound
    localparam logic [ELEM_W:0]  ELEM_LIMIT  = (ELEM_W + 1)'(ELEMENTS);
    localparam logic [QUEUE_W:0] QUEUE_LIMIT = (QUEUE_W + 1)'(QUEUES);

    typedef enum logic [ACTION_W-1:0] {
        ACT_APPEND = 2'd0,
        ACT_REMOVE = 2'd1,
        ACT_QUERY  = 2'd2
    } t_action;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [QUEUE_W-1:0]  queue_id;
        logic [ELEM_W-1:0]   elem_index;
    } t_req;

    typedef struct packed {
        logic               status;
        logic [COUNT_W-1:0] count;
        logic [ELEM_W-1:0]  head_index;
        logic               queue_nonempty;
    } t_rsp;

endpackage

`default_nettype wire

[design/circular_linked_queue_manager.sv]
// ----------------------------------------------------------------------------
// Circular linked queue manager
// Several circular doubly linked queues over one pool of element indices,
// with append, remove and query; owner tags and size counters avoid walks.
// ----------------------------------------------------------------------------
//   channel   handshake            payload
//   request   i_valid / o_ready    i_action, i_queue_id, i_elem_index
//   response  o_valid / i_ready    o_status, o_count, o_head_index,
//                                  o_queue_nonempty
//
// One transaction per cycle while the response side is not stalled; a request
// passes through the input register and then the result register before its
// response is valid. The list update is done in one pass between the two
// registers. Reset clears the linked flags and queue counts at once.
// When the response is stalled the input register fills and then o_ready
// drops; o_ready follows i_ready in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_linked_queue_manager (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [clqm_pkg::ACTION_W-1:0]   i_action,
    input  wire logic [clqm_pkg::QUEUE_W-1:0]    i_queue_id,
    input  wire logic [clqm_pkg::ELEM_W-1:0]     i_elem_index,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic                                 o_status,
    output logic [clqm_pkg::COUNT_W-1:0]         o_count,
    output logic [clqm_pkg::ELEM_W-1:0]          o_head_index,
    output logic                                 o_queue_nonempty
);

    clqm_pkg::t_req in_req;
    clqm_pkg::t_req cur_req;
    clqm_pkg::t_rsp core_rsp;
    clqm_pkg::t_rsp out_rsp;
    logic           cur_valid;
    logic           out_free;
    logic           fire;

    assign in_req.action     = i_action;
    assign in_req.queue_id   = i_queue_id;
    assign in_req.elem_index = i_elem_index;

    assign fire = cur_valid && out_free;

    clqm_in_stage u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_req     (in_req),
        .i_advance (out_free),
        .o_valid   (cur_valid),
        .o_req     (cur_req)
    );

    clqm_list_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_req   (cur_req),
        .o_rsp   (core_rsp)
    );

    clqm_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (fire),
        .i_rsp   (core_rsp),
        .o_free  (out_free),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_rsp   (out_rsp)
    );

    assign o_status         = out_rsp.status;
    assign o_count          = out_rsp.count;
    assign o_head_index     = out_rsp.head_index;
    assign o_queue_nonempty = out_rsp.queue_nonempty;

endmodule

`default_nettype wire

[design/clqm_in_stage.sv]
// ----------------------------------------------------------------------------
// Circular linked queue manager - input register
// Captures one request transaction and holds it until the list logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module clqm_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire clqm_pkg::t_req i_req,
    input  wire logic          i_advance,
    output logic               o_valid,
    output clqm_pkg::t_req     o_req
);

    logic           r_valid;
    clqm_pkg::t_req r_req;

    assign o_ready = !r_valid || i_advance;
    assign o_valid = r_valid;
    assign o_req   = r_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_req <= i_req;
        end
    end

endmodule

`default_nettype wire

[design/clqm_list_core.sv]
// ----------------------------------------------------------------------------
// Circular linked queue manager - list state and update logic
// Holds the link, owner, head and count state, applies one operation per cycle
// while the result register is free and forms the addressed queue's response.
// ----------------------------------------------------------------------------
`default_nettype none

module clqm_list_core (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_fire,
    input  wire clqm_pkg::t_req i_req,
    output clqm_pkg::t_rsp      o_rsp
);

    localparam int EW = clqm_pkg::ELEM_W;
    localparam int QW = clqm_pkg::QUEUE_W;
    localparam int CW = clqm_pkg::COUNT_W;

    logic [EW-1:0] r_next   [clqm_pkg::ELEMENTS];
    logic [EW-1:0] r_prev   [clqm_pkg::ELEMENTS];
    logic [QW-1:0] r_owner  [clqm_pkg::ELEMENTS];
    logic          r_linked [clqm_pkg::ELEMENTS];
    logic [EW-1:0] r_head   [clqm_pkg::QUEUES];
    logic [CW-1:0] r_count  [clqm_pkg::QUEUES];

    logic [QW-1:0] q;
    logic [EW-1:0] e;
    logic          q_ok;
    logic          e_ok;
    logic [CW-1:0] cnt;
    logic [EW-1:0] head;
    logic [EW-1:0] nxt_e;
    logic [EW-1:0] prev_rd_idx;
    logic [EW-1:0] prev_rd;
    logic          app_ok;
    logic          rem_ok;
    logic          op_ok;
    logic          do_app;
    logic          do_rem;
    logic          multi;
    logic [CW-1:0] n_cnt;
    logic [EW-1:0] n_head;

    assign q     = i_req.queue_id;
    assign e     = i_req.elem_index;
    assign q_ok  = {1'b0, q} < clqm_pkg::QUEUE_LIMIT;
    assign e_ok  = {1'b0, e} < clqm_pkg::ELEM_LIMIT;
    assign cnt   = r_count[q];
    assign head  = r_head[q];
    assign nxt_e = r_next[e];
    assign multi = cnt > CW'(1);

    // Append needs the tail (prev of head), remove needs prev of the element
    assign prev_rd_idx = (i_req.action == clqm_pkg::ACT_APPEND) ? head : e;
    assign prev_rd     = r_prev[prev_rd_idx];

    assign app_ok = e_ok && !r_linked[e];
    assign rem_ok = e_ok && (cnt != '0) && r_linked[e] && (r_owner[e] == q);

    always_comb begin
        op_ok = 1'b0;
        case (i_req.action)
            clqm_pkg::ACT_APPEND: op_ok = app_ok;
            clqm_pkg::ACT_REMOVE: op_ok = rem_ok;
            clqm_pkg::ACT_QUERY:  op_ok = 1'b1;
            default:              op_ok = 1'b0;
        endcase
    end

    assign do_app = i_fire && q_ok && app_ok && (i_req.action == clqm_pkg::ACT_APPEND);
    assign do_rem = i_fire && q_ok && rem_ok && (i_req.action == clqm_pkg::ACT_REMOVE);

    always_comb begin
        n_cnt  = cnt;
        n_head = head;
        if (q_ok && op_ok && i_req.action == clqm_pkg::ACT_APPEND) begin
            n_cnt = cnt + CW'(1);
            if (cnt == '0) begin
                n_head = e;
            end
        end else if (q_ok && op_ok && i_req.action == clqm_pkg::ACT_REMOVE) begin
            n_cnt = cnt - CW'(1);
            if (multi && head == e) begin
                n_head = nxt_e;
            end
        end
    end

    always_comb begin
        o_rsp = '0;
        if (q_ok) begin
            o_rsp.status         = op_ok ? clqm_pkg::STATUS_OK : clqm_pkg::STATUS_ERR;
            o_rsp.count          = n_cnt;
            o_rsp.queue_nonempty = (n_cnt != '0);
            o_rsp.head_index     = (n_cnt != '0) ? n_head : '0;
        end else begin
            o_rsp.status = clqm_pkg::STATUS_ERR;
        end
    end

    // Link, owner and head stores: no reset, only read once written
    always_ff @(posedge i_clk) begin
        if (do_app) begin
            r_owner[e] <= q;
            if (cnt == '0) begin
                r_head[q] <= e;
                r_next[e] <= e;
                r_prev[e] <= e;
            end else begin
                r_next[prev_rd] <= e;
                r_prev[e]       <= prev_rd;
                r_next[e]       <= head;
                r_prev[head]    <= e;
            end
        end else if (do_rem && multi) begin
            r_next[prev_rd] <= nxt_e;
            r_prev[nxt_e]   <= prev_rd;
            if (head == e) begin
                r_head[q] <= nxt_e;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < clqm_pkg::ELEMENTS; i++) begin
                r_linked[i] <= 1'b0;
            end
            for (int j = 0; j < clqm_pkg::QUEUES; j++) begin
                r_count[j] <= '0;
            end
        end else if (do_app || do_rem) begin
            r_linked[e] <= do_app;
            r_count[q]  <= n_cnt;
        end
    end

endmodule

`default_nettype wire

[design/clqm_out_stage.sv]
// ----------------------------------------------------------------------------
// Circular linked queue manager - result register
// Holds one response transaction until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module clqm_out_stage (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_load,
    input  wire clqm_pkg::t_rsp i_rsp,
    output logic                o_free,
    output logic                o_valid,
    input  wire logic           i_ready,
    output clqm_pkg::t_rsp      o_rsp
);

    logic           r_valid;
    clqm_pkg::t_rsp r_rsp;

    assign o_free  = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rsp <= i_rsp;
        end
    end

endmodule

`default_nettype wire

[design/clqm_checker.sv]
// ----------------------------------------------------------------------------
// Circular linked queue manager - port checker
// Watches the top-level ports for response consistency and stall behavior.
// ----------------------------------------------------------------------------
`default_nettype none

module clqm_checker (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_valid,
    input wire logic                          o_ready,
    input wire logic                          o_valid,
    input wire logic                          i_ready,
    input wire logic                          o_status,
    input wire logic [clqm_pkg::COUNT_W-1:0]  o_count,
    input wire logic [clqm_pkg::ELEM_W-1:0]   o_head_index,
    input wire logic                          o_queue_nonempty
);

    // An empty queue reports zero count and zero head
    a_empty_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_queue_nonempty) |-> (o_count == '0 && o_head_index == '0))
        else $error("empty queue reported with nonzero count or head");

    a_nonempty_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_queue_nonempty) |->
            (o_count != '0 &&
             o_count <= clqm_pkg::COUNT_W'(clqm_pkg::ELEMENTS)))
        else $error("nonempty queue count out of range");

    // Nothing comes out the cycle after reset
    a_reset_idle : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid right after reset");

    a_stall_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
            (o_valid && $stable(o_status) && $stable(o_count) &&
             $stable(o_head_index) && $stable(o_queue_nonempty)))
        else $error("stalled response changed");

    // With the response slot open, the request side must be ready
    a_ready_when_open : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_valid && !$past(i_valid && o_ready)) |-> o_ready)
        else $error("request side not ready with pipeline empty");

endmodule

bind circular_linked_queue_manager clqm_checker u_clqm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_ready          (o_ready),
    .o_valid          (o_valid),
    .i_ready          (i_ready),
    .o_status         (o_status),
    .o_count          (o_count),
    .o_head_index     (o_head_index),
    .o_queue_nonempty (o_queue_nonempty)
);

`default_nettype wire
